>>> src/stereo_ladder_lowpass_filter_top_defines.svh
// Assertion macros shared by the stereo ladder filter RTL.
`ifndef STEREO_LADDER_LOWPASS_FILTER_TOP_DEFINES_SVH
`define STEREO_LADDER_LOWPASS_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define SLF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SLF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/slf_pkg.sv
// Shared types, constants and microcode ROM of the stereo ladder filter.
package slf_pkg;

  localparam int SLF_STATE_BITS = 24;
  localparam int SLF_B_W        = 19;
  localparam int SLF_ENTRIES    = 8;
  localparam int SLF_ENT_W      = 3;
  localparam int SLF_PC_W       = 5;

  localparam logic [SLF_PC_W-1:0] SLF_LAST_STEP = 5'd22;

  localparam logic [15:0] SLF_CUT_MIN = 16'd66;
  localparam logic [15:0] SLF_CUT_MAX = 16'd64881;

  localparam logic signed [SLF_B_W-1:0] SLF_OMEGA_SCALE = 19'sd58982;
  localparam logic signed [SLF_B_W-1:0] SLF_RES_SCALE   = 19'sd249037;

  localparam logic [15:0] SLF_CUTOFF_RST = 16'd65535;
  localparam logic [15:0] SLF_RES_RST    = 16'd0;
  localparam logic [15:0] SLF_GAIN_RST   = 16'd52429;
  localparam logic [17:0] SLF_DEPTH_RST  = 18'd0;

  // Stage store layout: left stages 0..3, right stages 4..7.
  localparam logic [SLF_ENT_W-1:0] ST_L0 = 3'd0;
  localparam logic [SLF_ENT_W-1:0] ST_L1 = 3'd1;
  localparam logic [SLF_ENT_W-1:0] ST_L2 = 3'd2;
  localparam logic [SLF_ENT_W-1:0] ST_L3 = 3'd3;
  localparam logic [SLF_ENT_W-1:0] ST_R0 = 3'd4;
  localparam logic [SLF_ENT_W-1:0] ST_R1 = 3'd5;
  localparam logic [SLF_ENT_W-1:0] ST_R2 = 3'd6;
  localparam logic [SLF_ENT_W-1:0] ST_R3 = 3'd7;

  typedef enum logic [1:0] {
    J_NEXT,
    J_HOLD_IN,
    J_HOLD_OUT
  } slf_jmp_t;

  typedef enum logic [2:0] {
    A_E2C,
    A_RES,
    A_MOD,
    A_RDA,
    A_XDIFF,
    A_SDIFF,
    A_T
  } slf_asel_t;

  typedef enum logic [2:0] {
    B_ENV,
    B_RES_SCALE,
    B_OMEGA_SCALE,
    B_FB,
    B_OMEGA,
    B_GAIN
  } slf_bsel_t;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_IN,
    WB_MOD,
    WB_FB,
    WB_OMEGA,
    WB_X,
    WB_STAGE,
    WB_T,
    WB_OUTL,
    WB_OUT
  } slf_wb_t;

  typedef struct packed {
    slf_jmp_t              jmp;
    logic [SLF_PC_W-1:0]   target;
    logic                  mul_en;
    slf_asel_t             a_sel;
    slf_bsel_t             b_sel;
    logic                  mch;
    slf_wb_t               wb;
    logic                  wch;
    logic [SLF_ENT_W-1:0]  ra;
    logic [SLF_ENT_W-1:0]  rb;
    logic [SLF_ENT_W-1:0]  wa;
  } slf_cw_t;

  typedef struct packed {
    slf_cw_t cw;
    logic    fire;
  } slf_ctl_t;

  typedef struct packed {
    logic [15:0] cutoff;
    logic [15:0] resonance;
    logic [15:0] output_gain;
    logic [17:0] env_to_cutoff;
  } slf_cfg_t;

  function automatic slf_cw_t slf_word(
    input slf_jmp_t             j,
    input logic [SLF_PC_W-1:0]  tgt,
    input logic                 mul,
    input slf_asel_t            a,
    input slf_bsel_t            b,
    input logic                 mch,
    input slf_wb_t              wb,
    input logic                 wch,
    input logic [SLF_ENT_W-1:0] ra,
    input logic [SLF_ENT_W-1:0] rb,
    input logic [SLF_ENT_W-1:0] wa
  );
    slf_cw_t w;
    w.jmp    = j;
    w.target = tgt;
    w.mul_en = mul;
    w.a_sel  = a;
    w.b_sel  = b;
    w.mch    = mch;
    w.wb     = wb;
    w.wch    = wch;
    w.ra     = ra;
    w.rb     = rb;
    w.wa     = wa;
    return w;
  endfunction

  // Microcode: multiply issue and writeback of the previous product overlap.
  // Stage store reads land in the step after issue.
  function automatic slf_cw_t slf_ucode(input logic [SLF_PC_W-1:0] pc);
    slf_cw_t w;
    case (pc)
      5'd0:  w = slf_word(J_HOLD_IN, '0, 1'b0, A_RDA, B_FB, 1'b0, WB_IN, 1'b0,
                          ST_L0, ST_L0, ST_L0);
      5'd1:  w = slf_word(J_NEXT, '0, 1'b1, A_E2C, B_ENV, 1'b0, WB_NONE, 1'b0,
                          ST_L0, ST_L0, ST_L0);
      5'd2:  w = slf_word(J_NEXT, '0, 1'b1, A_RES, B_RES_SCALE, 1'b0, WB_MOD, 1'b0,
                          ST_L0, ST_L0, ST_L0);
      5'd3:  w = slf_word(J_NEXT, '0, 1'b1, A_MOD, B_OMEGA_SCALE, 1'b0, WB_FB, 1'b0,
                          ST_L3, ST_L0, ST_L0);
      5'd4:  w = slf_word(J_NEXT, '0, 1'b1, A_RDA, B_FB, 1'b0, WB_OMEGA, 1'b0,
                          ST_R3, ST_L0, ST_L0);
      5'd5:  w = slf_word(J_NEXT, '0, 1'b1, A_RDA, B_FB, 1'b0, WB_X, 1'b0,
                          ST_L0, ST_L0, ST_L0);
      5'd6:  w = slf_word(J_NEXT, '0, 1'b1, A_XDIFF, B_OMEGA, 1'b0, WB_X, 1'b1,
                          ST_L0, ST_R0, ST_L0);
      5'd7:  w = slf_word(J_NEXT, '0, 1'b1, A_XDIFF, B_OMEGA, 1'b1, WB_STAGE, 1'b0,
                          ST_L0, ST_L0, ST_L0);
      5'd8:  w = slf_word(J_NEXT, '0, 1'b0, A_SDIFF, B_OMEGA, 1'b0, WB_STAGE, 1'b0,
                          ST_L0, ST_L1, ST_R0);
      5'd9:  w = slf_word(J_NEXT, '0, 1'b1, A_SDIFF, B_OMEGA, 1'b0, WB_NONE, 1'b0,
                          ST_R0, ST_R1, ST_L0);
      5'd10: w = slf_word(J_NEXT, '0, 1'b1, A_SDIFF, B_OMEGA, 1'b0, WB_STAGE, 1'b0,
                          ST_L0, ST_L0, ST_L1);
      5'd11: w = slf_word(J_NEXT, '0, 1'b0, A_SDIFF, B_OMEGA, 1'b0, WB_STAGE, 1'b0,
                          ST_L1, ST_L2, ST_R1);
      5'd12: w = slf_word(J_NEXT, '0, 1'b1, A_SDIFF, B_OMEGA, 1'b0, WB_NONE, 1'b0,
                          ST_R1, ST_R2, ST_L0);
      5'd13: w = slf_word(J_NEXT, '0, 1'b1, A_SDIFF, B_OMEGA, 1'b0, WB_STAGE, 1'b0,
                          ST_L0, ST_L0, ST_L2);
      5'd14: w = slf_word(J_NEXT, '0, 1'b0, A_SDIFF, B_OMEGA, 1'b0, WB_STAGE, 1'b0,
                          ST_L2, ST_L3, ST_R2);
      5'd15: w = slf_word(J_NEXT, '0, 1'b1, A_SDIFF, B_OMEGA, 1'b0, WB_NONE, 1'b0,
                          ST_R2, ST_R3, ST_L0);
      5'd16: w = slf_word(J_NEXT, '0, 1'b1, A_SDIFF, B_OMEGA, 1'b0, WB_STAGE, 1'b0,
                          ST_L0, ST_L0, ST_L3);
      5'd17: w = slf_word(J_NEXT, '0, 1'b0, A_RDA, B_ENV, 1'b0, WB_STAGE, 1'b0,
                          ST_L3, ST_L0, ST_R3);
      5'd18: w = slf_word(J_NEXT, '0, 1'b1, A_RDA, B_ENV, 1'b0, WB_NONE, 1'b0,
                          ST_R3, ST_L0, ST_L0);
      5'd19: w = slf_word(J_NEXT, '0, 1'b1, A_RDA, B_ENV, 1'b0, WB_T, 1'b0,
                          ST_L0, ST_L0, ST_L0);
      5'd20: w = slf_word(J_NEXT, '0, 1'b1, A_T, B_GAIN, 1'b0, WB_T, 1'b1,
                          ST_L0, ST_L0, ST_L0);
      5'd21: w = slf_word(J_NEXT, '0, 1'b1, A_T, B_GAIN, 1'b1, WB_OUTL, 1'b0,
                          ST_L0, ST_L0, ST_L0);
      5'd22: w = slf_word(J_HOLD_OUT, '0, 1'b0, A_RDA, B_FB, 1'b0, WB_OUT, 1'b0,
                          ST_L0, ST_L0, ST_L0);
      default: w = slf_word(J_HOLD_OUT, '0, 1'b0, A_RDA, B_FB, 1'b0, WB_NONE, 1'b0,
                            ST_L0, ST_L0, ST_L0);
    endcase
    return w;
  endfunction

endpackage

>>> src/slf_ram.sv
// Generic RAM: one write port, two registered read ports.
module slf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic [WIDTH-1:0]         ra_data,
  input  logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] ra_data_r;
  logic [WIDTH-1:0] rb_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    ra_data_r <= mem_r[ra_addr];
    rb_data_r <= mem_r[rb_addr];
  end

  assign ra_data = ra_data_r;
  assign rb_data = rb_data_r;

endmodule

>>> src/slf_seq.sv
// Microcode sequencer: step counter, control ROM and hold conditions.
`include "stereo_ladder_lowpass_filter_top_defines.svh"

module slf_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              out_blocked,
  output slf_pkg::slf_ctl_t ctl
);

  import slf_pkg::*;

  logic [SLF_PC_W-1:0] pc_r;
  logic [SLF_PC_W-1:0] pc_nxt;
  slf_cw_t             cw;
  logic                fire;

  assign cw = slf_ucode(pc_r);

  always_comb begin
    case (cw.jmp)
      J_NEXT:     fire = 1'b1;
      J_HOLD_IN:  fire = in_valid;
      J_HOLD_OUT: fire = !out_blocked;
      default:    fire = 1'b0;
    endcase
  end

  always_comb begin
    case (cw.jmp)
      J_NEXT:     pc_nxt = pc_r + 1'b1;
      J_HOLD_IN:  pc_nxt = fire ? pc_r + 1'b1 : pc_r;
      J_HOLD_OUT: pc_nxt = fire ? cw.target : pc_r;
      default:    pc_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign in_stall = (cw.jmp != J_HOLD_IN);
  assign ctl.cw   = cw;
  assign ctl.fire = fire;

  `SLF_ASSERT_NOW(a_pc_range, 1'b1, pc_r <= SLF_LAST_STEP, "step counter past program end")
  `SLF_ASSERT_NOW(a_take_at_start, !in_stall, pc_r == '0, "input taken outside first step")
  `SLF_ASSERT_NEXT(a_wrap, (cw.jmp == J_HOLD_OUT) && fire, pc_r == '0, "no return to start")

endmodule

>>> src/slf_dp.sv
// Datapath: shared multiplier, rounding, writeback ALU and stage store.
`include "stereo_ladder_lowpass_filter_top_defines.svh"

module slf_dp #(
  parameter int STATE_BITS = slf_pkg::SLF_STATE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  slf_pkg::slf_ctl_t  ctl,
  input  slf_pkg::slf_cfg_t  cfg,
  input  logic signed [17:0] in_left_in,
  input  logic signed [17:0] in_right_in,
  input  logic [16:0]        in_envelope,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] out_left_out,
  output logic signed [17:0] out_right_out,
  output logic               out_blocked
);

  import slf_pkg::*;

  localparam int S   = STATE_BITS;
  localparam int AW  = S + 4;
  localparam int BW  = SLF_B_W;
  localparam int PW  = AW + BW;
  localparam int XW  = S + 4;
  localparam int SW3 = S + 3;
  localparam int TW  = S + 1;
  localparam int MW  = 21;
  localparam int OW  = 21;
  localparam int OSH = S - 2;
  localparam int XSH = S - 18;

  localparam logic signed [PW:0]    HALF16 = (PW+1)'(64'sd1 <<< 15);
  localparam logic signed [PW:0]    HALFO  = (PW+1)'(64'sd1 <<< (OSH - 1));
  localparam longint                CLIP_L = ((64'sd12 <<< (S - 4)) + 64'sd5) / 64'sd10;
  localparam logic signed [XW-1:0]  CLIP   = XW'(CLIP_L);
  localparam logic signed [XW-1:0]  NCLIP  = -CLIP;
  localparam logic signed [SW3-1:0] SMAX   = SW3'((64'sd1 <<< (S - 1)) - 64'sd1);
  localparam logic signed [SW3-1:0] SMIN   = -SMAX - SW3'(1);
  localparam logic signed [OW-1:0]  OMAX   = 21'sd131071;
  localparam logic signed [OW-1:0]  OMIN   = -21'sd131072;
  localparam logic signed [MW-1:0]  MMIN   = MW'(SLF_CUT_MIN);
  localparam logic signed [MW-1:0]  MMAX   = MW'(SLF_CUT_MAX);

  // captured item and coefficients
  logic signed [17:0]   left_r, right_r;
  logic [16:0]          env_r;
  logic [15:0]          mod_r;
  logic [15:0]          omega_r;
  logic [17:0]          fb_r;
  logic signed [S-1:0]  x_r [2];
  logic signed [TW-1:0] t_r [2];
  logic signed [17:0]   lo_r;
  logic signed [17:0]   out_left_r, out_right_r;
  logic                 out_valid_r;

  logic signed [PW-1:0] p_r, p_nxt;
  logic signed [S-1:0]  acc_r;

  logic [SLF_ENTRIES-1:0] vld_r;
  logic                   va_r, vb_r;
  logic [S-1:0]           ram_a, ram_b;
  logic signed [S-1:0]    rda, rdb;

  logic signed [AW-1:0]   a_op;
  logic signed [BW-1:0]   b_op;
  logic signed [PW:0]     p_ext, r16, r_o, r;

  logic signed [MW-1:0]   msum;
  logic [15:0]            mod_nxt;
  logic signed [17:0]     in_sel;
  logic signed [XW-1:0]   xs, x_raw;
  logic signed [S-1:0]    x_nxt;
  logic signed [SW3-1:0]  st_sum;
  logic signed [S-1:0]    stage_nxt;
  logic signed [OW-1:0]   o_raw;
  logic signed [17:0]     o_sat;
  logic                   ram_we;
  logic                   publish;

  // stage store; entries never written read as zero
  slf_ram #(.WIDTH(S), .DEPTH(SLF_ENTRIES)) u_stages (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ctl.cw.wa),
    .wdata   (stage_nxt),
    .ra_addr (ctl.cw.ra),
    .ra_data (ram_a),
    .rb_addr (ctl.cw.rb),
    .rb_data (ram_b)
  );

  assign rda = va_r ? $signed(ram_a) : '0;
  assign rdb = vb_r ? $signed(ram_b) : '0;

  always_comb begin
    case (ctl.cw.a_sel)
      A_E2C:   a_op = AW'($signed(cfg.env_to_cutoff));
      A_RES:   a_op = $signed(AW'(cfg.resonance));
      A_MOD:   a_op = $signed(AW'(mod_r));
      A_RDA:   a_op = AW'(rda);
      A_XDIFF: a_op = AW'(x_r[ctl.cw.mch]) - AW'(rdb);
      A_SDIFF: a_op = AW'(rda) - AW'(rdb);
      A_T:     a_op = AW'(t_r[ctl.cw.mch]);
      default: a_op = '0;
    endcase
  end

  always_comb begin
    case (ctl.cw.b_sel)
      B_ENV:         b_op = $signed(BW'(env_r));
      B_RES_SCALE:   b_op = SLF_RES_SCALE;
      B_OMEGA_SCALE: b_op = SLF_OMEGA_SCALE;
      B_FB:          b_op = $signed(BW'(fb_r));
      B_OMEGA:       b_op = $signed(BW'(omega_r));
      B_GAIN:        b_op = $signed(BW'(cfg.output_gain));
      default:       b_op = '0;
    endcase
  end

  assign p_nxt = a_op * b_op;

  // round half up, floor shift
  assign p_ext = (PW+1)'(p_r);
  assign r16   = (p_ext + HALF16) >>> 16;
  assign r_o   = (p_ext + HALFO) >>> OSH;
  assign r     = (ctl.cw.wb == WB_OUTL || ctl.cw.wb == WB_OUT) ? r_o : r16;

  // modulated cutoff with clamp
  always_comb begin
    msum = $signed(MW'(cfg.cutoff)) + $signed(r[MW-1:0]);
    if (msum < MMIN) begin
      mod_nxt = SLF_CUT_MIN;
    end else if (msum > MMAX) begin
      mod_nxt = SLF_CUT_MAX;
    end else begin
      mod_nxt = msum[15:0];
    end
  end

  // feedback subtraction and input clip
  always_comb begin
    in_sel = ctl.cw.wch ? right_r : left_r;
    xs     = XW'(in_sel) <<< XSH;
    x_raw  = xs - $signed(r[XW-1:0]);
    if (x_raw > CLIP) begin
      x_nxt = CLIP[S-1:0];
    end else if (x_raw < NCLIP) begin
      x_nxt = NCLIP[S-1:0];
    end else begin
      x_nxt = x_raw[S-1:0];
    end
  end

  // one-pole update with saturation
  always_comb begin
    st_sum = SW3'(acc_r) + $signed(r[SW3-1:0]);
    if (st_sum > SMAX) begin
      stage_nxt = SMAX[S-1:0];
    end else if (st_sum < SMIN) begin
      stage_nxt = SMIN[S-1:0];
    end else begin
      stage_nxt = st_sum[S-1:0];
    end
  end

  always_comb begin
    o_raw = $signed(r[OW-1:0]);
    if (o_raw > OMAX) begin
      o_sat = OMAX[17:0];
    end else if (o_raw < OMIN) begin
      o_sat = OMIN[17:0];
    end else begin
      o_sat = o_raw[17:0];
    end
  end

  assign ram_we      = (ctl.cw.wb == WB_STAGE);
  assign publish     = (ctl.cw.wb == WB_OUT) && ctl.fire;
  assign out_blocked = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (ctl.cw.mul_en) begin
      p_r   <= p_nxt;
      acc_r <= rdb;
    end
    case (ctl.cw.wb)
      WB_IN: begin
        if (ctl.fire) begin
          left_r  <= in_left_in;
          right_r <= in_right_in;
          env_r   <= in_envelope;
        end
      end
      WB_MOD:   mod_r              <= mod_nxt;
      WB_FB:    fb_r               <= r[17:0];
      WB_OMEGA: omega_r            <= r[15:0];
      WB_X:     x_r[ctl.cw.wch]    <= x_nxt;
      WB_T:     t_r[ctl.cw.wch]    <= $signed(r[TW-1:0]);
      WB_OUTL:  lo_r               <= o_sat;
      WB_OUT: begin
        if (ctl.fire) begin
          out_left_r  <= lo_r;
          out_right_r <= o_sat;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
    end else begin
      if (publish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (ram_we) begin
        vld_r[ctl.cw.wa] <= 1'b1;
      end
      va_r <= vld_r[ctl.cw.ra];
      vb_r <= vld_r[ctl.cw.rb];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

  `SLF_ASSERT_NEXT(a_mod_clamped, ctl.cw.wb == WB_MOD, (mod_r >= SLF_CUT_MIN) && (mod_r <= SLF_CUT_MAX), "cutoff outside clamp")
  `SLF_ASSERT_NOW(a_no_overwrite, publish, !out_blocked, "result overwritten while held")
  `SLF_ASSERT_NEXT(a_publish_valid, publish, out_valid_r, "published result not shown")

endmodule

>>> src/stereo_ladder_lowpass_filter_top.sv
// Top level of the stereo four-pole ladder low-pass filter.
// The input beat is captured at the first program step and the result is registered at
// the last; a new beat is taken only after the 23-step microcode program, which runs
//   every multiply of both channels through one multiplier, has run to its end.
// A held result stalls the program at its last step until the beat is taken.
// Reset (rst_n low, synchronous): registers to defaults, stage state reads as zero.
module stereo_ladder_lowpass_filter_top #(
  parameter int STATE_BITS = slf_pkg::SLF_STATE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [17:0] in_left_in,
  input  logic signed [17:0] in_right_in,
  input  logic [16:0]        in_envelope,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] out_left_out,
  output logic signed [17:0] out_right_out,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import slf_pkg::*;

  // register offsets, word aligned
  localparam logic [1:0] REG_CUTOFF    = 2'd0;
  localparam logic [1:0] REG_RESONANCE = 2'd1;
  localparam logic [1:0] REG_GAIN      = 2'd2;
  localparam logic [1:0] REG_DEPTH     = 2'd3;

  slf_cfg_t   cfg_r;
  slf_ctl_t   ctl;
  logic       cfg_wr;
  logic [1:0] reg_idx;
  logic       out_blocked;

  // APB: no wait states, write lands on the access phase
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cutoff        <= SLF_CUTOFF_RST;
      cfg_r.resonance     <= SLF_RES_RST;
      cfg_r.output_gain   <= SLF_GAIN_RST;
      cfg_r.env_to_cutoff <= SLF_DEPTH_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_CUTOFF:    cfg_r.cutoff        <= pwdata[15:0];
        REG_RESONANCE: cfg_r.resonance     <= pwdata[15:0];
        REG_GAIN:      cfg_r.output_gain   <= pwdata[15:0];
        REG_DEPTH:     cfg_r.env_to_cutoff <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CUTOFF:    prdata = 32'(cfg_r.cutoff);
      REG_RESONANCE: prdata = 32'(cfg_r.resonance);
      REG_GAIN:      prdata = 32'(cfg_r.output_gain);
      REG_DEPTH:     prdata = 32'(cfg_r.env_to_cutoff);
      default:       prdata = '0;
    endcase
  end

  // Sequencer steps the control ROM; the datapath executes each control word:
  // coefficient setup, feedback and clip per channel, four interleaved stage
  // updates per channel, then envelope and gain scaling into the output register.
  slf_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_blocked (out_blocked),
    .ctl         (ctl)
  );

  slf_dp #(.STATE_BITS(STATE_BITS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .cfg           (cfg_r),
    .in_left_in    (in_left_in),
    .in_right_in   (in_right_in),
    .in_envelope   (in_envelope),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_left_out  (out_left_out),
    .out_right_out (out_right_out),
    .out_blocked   (out_blocked)
  );

endmodule

>>> tb/tb_stereo_ladder_lowpass_filter_top.sv
// Self-checking testbench for the stereo four-pole ladder low-pass filter.
`timescale 1ns / 100ps

module tb_stereo_ladder_lowpass_filter_top;

  // Stage state width comes from the package so the predictor tracks the DUT build.
  localparam int SB   = slf_pkg::SLF_STATE_BITS;
  localparam int FRAC = SB - 4;

  // Register byte addresses, one 32-bit word per register.
  localparam logic [3:0] REG_CUTOFF = 4'd0;
  localparam logic [3:0] REG_RESO   = 4'd4;
  localparam logic [3:0] REG_GAIN   = 4'd8;
  localparam logic [3:0] REG_DEPTH  = 4'd12;

  // Filter constants, Q0.16 / Q2.16.
  localparam longint CUT_LO     = 66;
  localparam longint CUT_HI     = 64881;
  localparam longint OMEGA_MUL  = 58982;
  localparam longint RESO_MUL   = 249037;

  localparam int N_DIRECTED     = 20;
  localparam int N_PHASES       = 10;
  localparam int BEATS_PER_PHASE = 175;
  localparam int CALM_PHASE     = 4;    // no idling on either side here
  localparam int DRAIN_PHASE    = 6;    // sender drains the pipe mid-phase
  localparam int TAIL_CYCLES    = 30;   // idle margin after the final drain

  typedef struct packed {
    logic signed [17:0] left;
    logic signed [17:0] right;
  } stereo_t;

  typedef struct packed {
    logic signed [17:0] left;
    logic signed [17:0] right;
    logic [16:0]        env;
    logic               known;   // expected value typed in below
    logic signed [17:0] exp_left;
    logic signed [17:0] exp_right;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [17:0] in_left_in;
  logic signed [17:0] in_right_in;
  logic [16:0]        in_envelope;
  logic               out_valid;
  logic               out_stall;
  logic signed [17:0] out_left_out;
  logic signed [17:0] out_right_out;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // Predictor copy of the registers and the two ladders.
  logic [15:0]          cut_reg;
  logic [15:0]          reso_reg;
  logic [15:0]          gain_reg;
  logic signed [17:0]   depth_reg;
  logic signed [SB-1:0] pole [2][4];

  stereo_t pending_q[$];
  int      fails;
  int      beats_sent;
  int      beats_seen;
  bit      calm;

  stereo_ladder_lowpass_filter_top #(.STATE_BITS(SB)) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_left_in   (in_left_in),
    .in_right_in  (in_right_in),
    .in_envelope  (in_envelope),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_left_out (out_left_out),
    .out_right_out(out_right_out),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop, far beyond a worst-case correct run.
  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $display("timeout: %0d beats sent, %0d results seen", beats_sent, beats_seen);
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Add half an LSB, then floor shift.
  function automatic longint rnd_sh(longint x, int n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp_w(longint x, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (x > hi) return hi;
    if (x < -hi - 1) return -hi - 1;
    return x;
  endfunction

  // One channel: feedback, input clip, four one-pole stages, envelope and gain.
  function automatic logic signed [17:0] ladder_channel(int ch, longint smp, longint omega,
                                                        longint fbk, longint env);
    longint clip;
    longint x;
    longint src;
    longint s;
    longint t;
    clip = ((longint'(12) <<< FRAC) + 5) / 10;
    x = smp * (longint'(1) <<< (FRAC - 14));
    x = x - rnd_sh(fbk * longint'(pole[ch][3]), 16);
    if (x > clip) x = clip;
    else if (x < -clip) x = -clip;
    for (int k = 0; k < 4; k++) begin
      src = (k == 0) ? x : longint'(pole[ch][k-1]);
      s   = longint'(pole[ch][k]);
      pole[ch][k] = clamp_w(s + rnd_sh(omega * (src - s), 16), SB);
    end
    t = rnd_sh(longint'(pole[ch][3]) * env, 16);
    return clamp_w(rnd_sh(t * longint'(gain_reg), 16 + FRAC - 14), 18);
  endfunction

  function automatic stereo_t filter_sample(logic signed [17:0] l, logic signed [17:0] r,
                                            logic [16:0] env);
    longint e;
    longint md;
    longint omega;
    longint fbk;
    stereo_t res;
    e  = longint'(env);
    md = longint'(cut_reg) + rnd_sh(e * longint'(depth_reg), 16);
    if (md < CUT_LO) md = CUT_LO;
    else if (md > CUT_HI) md = CUT_HI;
    omega = rnd_sh(md * OMEGA_MUL, 16);
    fbk   = rnd_sh(longint'(reso_reg) * RESO_MUL, 16);
    res.left  = ladder_channel(0, longint'(l), omega, fbk, e);
    res.right = ladder_channel(1, longint'(r), omega, fbk, e);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. env = 0 forces a zero result whatever the state holds.
  // ---------------------------------------------------------------------------
  function automatic dir_row_t dir_row(int idx);
    dir_row_t row;
    row = '0;
    case (idx)
      0:  row = '{18'sd0, 18'sd0, 17'd0, 1'b1, 18'sd0, 18'sd0};           // right after reset
      1:  row = '{18'sd131071, -18'sd131072, 17'd0, 1'b1, 18'sd0, 18'sd0}; // full scale, env off
      2:  row = '{18'sd131071, -18'sd131072, 17'd65536, 1'b0, 18'sd0, 18'sd0};
      3:  row = '{18'sd131071, -18'sd131072, 17'd65536, 1'b0, 18'sd0, 18'sd0};
      4:  row = '{18'sd131071, -18'sd131072, 17'd131071, 1'b0, 18'sd0, 18'sd0}; // env > 1
      5:  row = '{-18'sd131072, 18'sd131071, 17'd131071, 1'b0, 18'sd0, 18'sd0};
      6:  row = '{-18'sd131072, 18'sd131071, 17'd65536, 1'b0, 18'sd0, 18'sd0};
      7:  row = '{18'sd0, 18'sd0, 17'd65536, 1'b0, 18'sd0, 18'sd0};        // decay
      8:  row = '{18'sd0, 18'sd0, 17'd0, 1'b1, 18'sd0, 18'sd0};
      9:  row = '{18'sd1, -18'sd1, 17'd65536, 1'b0, 18'sd0, 18'sd0};
      10: row = '{18'sd16384, -18'sd16384, 17'd32768, 1'b0, 18'sd0, 18'sd0};
      11: row = '{18'sd16384, -18'sd16384, 17'd1, 1'b0, 18'sd0, 18'sd0};
      12: row = '{-18'sd1, 18'sd1, 17'd65535, 1'b0, 18'sd0, 18'sd0};
      13: row = '{18'sd131071, 18'sd131071, 17'd65536, 1'b0, 18'sd0, 18'sd0};
      14: row = '{-18'sd131072, -18'sd131072, 17'd65536, 1'b0, 18'sd0, 18'sd0};
      15: row = '{18'sd8192, -18'sd8192, 17'd0, 1'b1, 18'sd0, 18'sd0};
      16: row = '{18'sd5000, -18'sd5000, 17'd100000, 1'b0, 18'sd0, 18'sd0};
      17: row = '{18'sd0, 18'sd0, 17'd131071, 1'b0, 18'sd0, 18'sd0};
      18: row = '{18'sd131071, -18'sd131072, 17'd65536, 1'b0, 18'sd0, 18'sd0};
      default: row = '{18'sd0, 18'sd0, 17'd65536, 1'b0, 18'sd0, 18'sd0};
    endcase
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // APB write with setup and access phases; entered and left at a falling edge.
  task automatic apb_write(logic [3:0] addr, logic [31:0] data);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Program all four registers; junk in the unused upper bits must be dropped.
  task automatic set_filter(logic [15:0] cut, logic [15:0] reso, logic [15:0] gain,
                            logic [17:0] depth);
    logic [31:0] junk;
    junk = ($urandom_range(0, 1) == 1) ? $urandom() : 32'd0;
    apb_write(REG_CUTOFF, {junk[31:16], cut});
    apb_write(REG_RESO,   {junk[15:0], reso});
    apb_write(REG_GAIN,   {junk[23:8], gain});
    apb_write(REG_DEPTH,  {junk[31:18], depth});
    cut_reg   = cut;
    reso_reg  = reso;
    gain_reg  = gain;
    depth_reg = depth;
  endtask

  // User writes config only when idle, not enforced by block: drain every pending result first.
  task automatic drain;
    in_valid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  // Offer one beat; on acceptance run the predictor and use its result unless a value is given.
  task automatic send_beat(logic signed [17:0] l, logic signed [17:0] r, logic [16:0] env,
                           bit known, stereo_t known_val);
    stereo_t exp_val;
    while (!calm && $urandom_range(0, 99) < 15) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    in_left_in  = l;
    in_right_in = r;
    in_envelope = env;
    do @(posedge clk); while (in_stall);
    exp_val = filter_sample(l, r, env);
    if (known) exp_val = known_val;
    pending_q.push_back(exp_val);
    beats_sent++;
    @(negedge clk);
  endtask

  // Random sample mix: mostly musical levels, some full scale and raw noise.
  task automatic pick_sample(output logic signed [17:0] l, output logic signed [17:0] r,
                             output logic [16:0] env);
    int mode;
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1: begin
        l = $urandom();
        r = $urandom();
      end
      2: begin
        l = $urandom_range(0, 1) ? 18'sd131071 : -18'sd131072;
        r = $urandom_range(0, 1) ? 18'sd131071 : -18'sd131072;
      end
      3: begin
        l = $signed(18'($urandom_range(0, 4000))) - 18'sd2000;
        r = $signed(18'($urandom_range(0, 4000))) - 18'sd2000;
      end
      default: begin
        l = $signed(18'($urandom_range(0, 65535))) - 18'sd32768;
        r = $signed(18'($urandom_range(0, 65535))) - 18'sd32768;
      end
    endcase
    mode = $urandom_range(0, 9);
    case (mode)
      0:       env = 17'd0;
      1:       env = 17'd65536;
      2:       env = $urandom();
      default: env = $urandom_range(0, 65536);
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall, and checking on every accepted beat
  // ---------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = (!calm && $urandom_range(0, 99) < 15);
    end
  end

  always @(posedge clk) begin
    stereo_t want;
    if (rst_n && out_valid && !out_stall) begin
      beats_seen++;
      if (pending_q.size() == 0) begin
        $error("result beat with nothing pending: left %0d right %0d",
               out_left_out, out_right_out);
        fails++;
      end else begin
        want = pending_q.pop_front();
        if (out_left_out !== want.left) begin
          $error("left_out: expected %0d, got %0d", want.left, out_left_out);
          fails++;
        end
        if (out_right_out !== want.right) begin
          $error("right_out: expected %0d, got %0d", want.right, out_right_out);
          fails++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t           row;
    stereo_t            kv;
    logic signed [17:0] l;
    logic signed [17:0] r;
    logic [16:0]        env;
    logic [17:0]        depth;

    fails       = 0;
    beats_sent  = 0;
    beats_seen  = 0;
    calm        = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_left_in  = '0;
    in_right_in = '0;
    in_envelope = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;

    // Predictor starts from the reset defaults.
    cut_reg   = 16'd65535;
    reso_reg  = 16'd0;
    gain_reg  = 16'd52429;
    depth_reg = 18'sd0;
    for (int c = 0; c < 2; c++)
      for (int k = 0; k < 4; k++)
        pole[c][k] = '0;

    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed beats under reset settings.
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = dir_row(i);
      kv.left  = row.exp_left;
      kv.right = row.exp_right;
      send_beat(row.left, row.right, row.env, row.known, kv);
    end

    // Random phases; the first five pin the register extremes.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      case (ph)
        0: set_filter(16'd0, 16'd0, 16'd65535, 18'd0);                 // clamp at low end
        1: set_filter(16'd65535, 16'd65535, 16'd65535, 18'h1FFFF);     // depth past +1
        2: set_filter(16'd32768, 16'd40000, 16'd52429, 18'h20000);     // depth past -1
        3: set_filter(16'd1000, 16'd65535, 16'd0, 18'h10000);          // zero gain
        4: set_filter(16'd60000, 16'd20000, 16'd40000, 18'h30000);     // depth -1
        default: begin
          if ($urandom_range(0, 1) == 1)
            depth = 18'($urandom_range(0, 131072)) - 18'd65536;
          else
            depth = $urandom();
          set_filter($urandom(), $urandom(), $urandom(), depth);
        end
      endcase
      calm = (ph == CALM_PHASE);
      for (int i = 0; i < BEATS_PER_PHASE; i++) begin
        if (ph == DRAIN_PHASE && i == BEATS_PER_PHASE / 2) drain();
        pick_sample(l, r, env);
        send_beat(l, r, env, 1'b0, kv);
      end
      calm = 1'b0;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d stereo beats, %0d results checked, over %0d register settings",
             beats_sent, beats_seen, N_PHASES + 1);
    $display("incl. cutoff clamps, full-range depth, envelope above one, input clip");
    if (fails == 0 && pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
